// ===== hdl/tcc_pkg.sv =====
// Shared types, codes and helper functions of the text console cursor engine.
package tcc_pkg;

	localparam int unsigned GLYPH_WIDTH  = 8;
	localparam int unsigned GLYPH_HEIGHT = 16;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	// Input commands
	localparam logic [1:0] CMD_CHAR  = 2'd0;
	localparam logic [1:0] CMD_BLOCK = 2'd1;
	localparam logic [1:0] CMD_SET   = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// Control characters
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BS  = 8'h08;

	// Draw order codes
	localparam logic [2:0] OP_GLYPH  = 3'd0;
	localparam logic [2:0] OP_ERASE  = 3'd1;
	localparam logic [2:0] OP_RECT   = 3'd2;
	localparam logic [2:0] OP_SCROLL = 3'd3;
	localparam logic [2:0] OP_FILL   = 3'd4;
	localparam logic [2:0] OP_CURSOR = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_FG_COLOR       = 2'd0;
	localparam logic [1:0] REG_BACKDROP_COLOR = 2'd1;
	localparam logic [1:0] REG_COLUMNS        = 2'd2;
	localparam logic [1:0] REG_ROWS           = 2'd3;

	typedef enum logic [2:0] {
		CL_NEWLINE   = 3'd0,
		CL_RETURN    = 3'd1,
		CL_TAB       = 3'd2,
		CL_BACKSPACE = 3'd3,
		CL_GLYPH     = 3'd4,
		CL_BLOCK     = 3'd5,
		CL_SET       = 3'd6,
		CL_CLEAR     = 3'd7
	} cls_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  char_code;
		logic [7:0]  block_cols;
		logic [7:0]  block_rows;
		logic [23:0] block_color;
		logic        block_newline;
		logic [7:0]  new_col;
		logic [7:0]  new_row;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [11:0] rect_w;
		logic [11:0] rect_h;
		logic [7:0]  glyph;
		logic [23:0] color;
		logic [7:0]  cursor_col_out;
		logic [7:0]  cursor_row_out;
		logic        last;
	} out_item_t;

	// Classified item as it waits in the queue; opa/opb are the column and
	// row operands of a block or a set cursor.
	typedef struct packed {
		cls_t        cls;
		logic [7:0]  char_code;
		logic [7:0]  opa;
		logic [7:0]  opb;
		logic [23:0] block_color;
		logic        block_newline;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [23:0] fg_color;
		logic [23:0] backdrop_color;
		logic [7:0]  columns;
		logic [7:0]  rows;
	} cfg_t;

	function automatic logic [7:0] sat8(input logic [8:0] v);
		return v[8] ? 8'hFF : v[7:0];
	endfunction

	// Cell index times a small glyph dimension, saturated to the pixel range.
	function automatic logic [11:0] cell_px(input logic [7:0] v, input logic [5:0] k);
		logic [13:0] p;
		p = 14'(v) * 14'(k);
		return (p > 14'd4095) ? 12'hFFF : p[11:0];
	endfunction

endpackage

// ===== hdl/tcc_cfg_if.sv =====
// Configuration write channel.
interface tcc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/tcc_in_if.sv =====
// Command channel carrying one input item.
interface tcc_in_if;
	logic               valid;
	logic               ready;
	tcc_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tcc_out_if.sv =====
// Draw order channel carrying one result item.
interface tcc_out_if;
	logic               valid;
	logic               ready;
	tcc_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tcc_fifo.sv =====
// Short queue of classified items between the front and back parts.
module tcc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tcc_pkg::q_entry_t   wr_entry,
	input  logic                pop,
	output tcc_pkg::q_entry_t   head,
	output tcc_pkg::q_stat_t    stat
);

	tcc_pkg::q_entry_t               mem_q [tcc_pkg::QDEPTH];
	logic [tcc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [tcc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [tcc_pkg::QPTR_W:0]        count_q;

	always_comb begin
		stat.full  = (count_q == (tcc_pkg::QPTR_W+1)'(tcc_pkg::QDEPTH));
		stat.empty = (count_q == '0);
		head       = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == (tcc_pkg::QPTR_W)'(tcc_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == (tcc_pkg::QPTR_W)'(tcc_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== hdl/tcc_front.sv =====
// Front part: accepts command items and classifies them for the queue.
module tcc_front (
	tcc_in_if.sink              req,
	input  tcc_pkg::q_stat_t    stat,
	output logic                push,
	output tcc_pkg::q_entry_t   entry
);

	always_comb begin
		req.ready = !stat.full;
		push      = req.valid && !stat.full;

		entry.char_code     = req.data.char_code;
		entry.block_color   = req.data.block_color;
		entry.block_newline = req.data.block_newline;
		entry.opa           = req.data.block_cols;
		entry.opb           = req.data.block_rows;
		entry.cls           = tcc_pkg::CL_CLEAR;

		case (req.data.cmd)
			tcc_pkg::CMD_CHAR: begin
				case (req.data.char_code)
					tcc_pkg::CH_LF:  entry.cls = tcc_pkg::CL_NEWLINE;
					tcc_pkg::CH_CR:  entry.cls = tcc_pkg::CL_RETURN;
					tcc_pkg::CH_TAB: entry.cls = tcc_pkg::CL_TAB;
					tcc_pkg::CH_BS:  entry.cls = tcc_pkg::CL_BACKSPACE;
					default:         entry.cls = tcc_pkg::CL_GLYPH;
				endcase
			end
			tcc_pkg::CMD_BLOCK: entry.cls = tcc_pkg::CL_BLOCK;
			tcc_pkg::CMD_SET: begin
				entry.cls = tcc_pkg::CL_SET;
				entry.opa = req.data.new_col;
				entry.opb = req.data.new_row;
			end
			default: entry.cls = tcc_pkg::CL_CLEAR;
		endcase
	end

endmodule

// ===== hdl/tcc_back.sv =====
// Back part: owns the cursor, carries out queued items and emits draw orders.
module tcc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tcc_pkg::cfg_t       cfg,
	input  tcc_pkg::q_entry_t   head,
	input  tcc_pkg::q_stat_t    stat,
	output logic                pop,
	tcc_out_if.source           rsp
);

	logic [7:0]          col_q;
	logic [7:0]          row_q;
	logic                out_valid_q;
	logic                pend_q;
	tcc_pkg::out_item_t  out_q;
	tcc_pkg::out_item_t  sec_q;

	logic [7:0]          ecols;
	logic [7:0]          erows;
	logic [7:0]          nc;
	logic [7:0]          nr;
	logic [8:0]          tab9;
	logic                has_pri;
	logic                wrap_chk;
	logic                scr_chk;
	logic                wrapped;
	logic                scroll;
	logic                two;
	logic                out_free;
	tcc_pkg::out_item_t  pri;
	tcc_pkg::out_item_t  scr;
	tcc_pkg::out_item_t  first;
	tcc_pkg::out_item_t  second;

	always_comb begin
		ecols    = (cfg.columns == 8'd0) ? 8'd1 : cfg.columns;
		erows    = (cfg.rows == 8'd0) ? 8'd1 : cfg.rows;
		nc       = col_q;
		nr       = row_q;
		tab9     = ({1'b0, col_q} + 9'd4) & ~9'd3;
		has_pri  = 1'b0;
		wrap_chk = 1'b0;
		scr_chk  = 1'b0;
		pri      = '0;

		case (head.cls)
			tcc_pkg::CL_NEWLINE: begin
				nc       = 8'd0;
				nr       = tcc_pkg::sat8({1'b0, row_q} + 9'd1);
				wrap_chk = 1'b1;
				scr_chk  = 1'b1;
			end
			tcc_pkg::CL_RETURN: begin
				nc       = 8'd0;
				wrap_chk = 1'b1;
				scr_chk  = 1'b1;
			end
			tcc_pkg::CL_TAB: begin
				nc       = tcc_pkg::sat8(tab9);
				wrap_chk = 1'b1;
				scr_chk  = 1'b1;
			end
			tcc_pkg::CL_BACKSPACE: begin
				wrap_chk = 1'b1;
				scr_chk  = 1'b1;
				// At the top-left cell nothing is erased.
				if (col_q != 8'd0) begin
					nc      = col_q - 8'd1;
					has_pri = 1'b1;
				end else if (row_q != 8'd0) begin
					nr      = row_q - 8'd1;
					nc      = ecols - 8'd1;
					has_pri = 1'b1;
				end
				pri.op      = tcc_pkg::OP_ERASE;
				pri.pixel_x = tcc_pkg::cell_px(nc, 6'(tcc_pkg::GLYPH_WIDTH));
				pri.pixel_y = tcc_pkg::cell_px(nr, 6'(tcc_pkg::GLYPH_HEIGHT));
				pri.rect_w  = 12'(tcc_pkg::GLYPH_WIDTH);
				pri.rect_h  = 12'(tcc_pkg::GLYPH_HEIGHT);
				pri.color   = cfg.backdrop_color;
			end
			tcc_pkg::CL_GLYPH: begin
				has_pri     = 1'b1;
				pri.op      = tcc_pkg::OP_GLYPH;
				pri.pixel_x = tcc_pkg::cell_px(col_q, 6'(tcc_pkg::GLYPH_WIDTH));
				pri.pixel_y = tcc_pkg::cell_px(row_q, 6'(tcc_pkg::GLYPH_HEIGHT));
				pri.glyph   = head.char_code;
				pri.color   = cfg.fg_color;
				nc          = tcc_pkg::sat8({1'b0, col_q} + 9'd1);
				wrap_chk    = 1'b1;
				scr_chk     = 1'b1;
			end
			tcc_pkg::CL_BLOCK: begin
				has_pri     = 1'b1;
				pri.op      = tcc_pkg::OP_RECT;
				pri.pixel_x = tcc_pkg::cell_px(col_q, 6'(tcc_pkg::GLYPH_WIDTH));
				pri.pixel_y = tcc_pkg::cell_px(row_q, 6'(tcc_pkg::GLYPH_HEIGHT));
				pri.rect_w  = tcc_pkg::cell_px(head.opa, 6'(tcc_pkg::GLYPH_WIDTH));
				pri.rect_h  = tcc_pkg::cell_px(head.opb, 6'(tcc_pkg::GLYPH_HEIGHT));
				pri.color   = head.block_color;
				if (head.block_newline) begin
					nc      = 8'd0;
					nr      = tcc_pkg::sat8({1'b0, row_q} + {1'b0, head.opb});
					scr_chk = 1'b1;
				end else begin
					// Without a newline the scroll test follows only a wrap.
					nc       = tcc_pkg::sat8({1'b0, col_q} + {1'b0, head.opa});
					wrap_chk = 1'b1;
				end
			end
			tcc_pkg::CL_SET: begin
				nc = head.opa;
				nr = head.opb;
			end
			default: begin
				has_pri   = 1'b1;
				pri.op    = tcc_pkg::OP_FILL;
				pri.color = cfg.backdrop_color;
				nc        = 8'd0;
				nr        = 8'd0;
			end
		endcase

		wrapped = wrap_chk && (nc >= ecols);
		if (wrapped) begin
			nc = 8'd0;
			nr = tcc_pkg::sat8({1'b0, nr} + 9'd1);
		end
		scroll = (scr_chk || wrapped) && (nr >= erows);
		if (scroll) begin
			nc = 8'd0;
			nr = erows - 8'd1;
		end

		scr       = '0;
		scr.op    = tcc_pkg::OP_SCROLL;
		scr.color = cfg.backdrop_color;

		if (has_pri) begin
			first = pri;
		end else if (scroll) begin
			first = scr;
		end else begin
			first    = '0;
			first.op = tcc_pkg::OP_CURSOR;
		end
		two                   = has_pri && scroll;
		first.cursor_col_out  = nc;
		first.cursor_row_out  = nr;
		first.last            = !two;
		second                = scr;
		second.cursor_col_out = nc;
		second.cursor_row_out = nr;
		second.last           = 1'b1;

		out_free = !out_valid_q || rsp.ready;
		pop      = !stat.empty && out_free && !pend_q;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= 8'd0;
			row_q       <= 8'd0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (pop) begin
				col_q       <= nc;
				row_q       <= nr;
				out_valid_q <= 1'b1;
				pend_q      <= two;
			end else if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= first;
			sec_q <= second;
		end else if (pend_q && out_free) begin
			out_q <= sec_q;
		end
	end

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: configuration registers and wiring.
//
//  channel  dir  handshake        payload
//  cfg      in   valid / ready    index (2), wdata (24)
//  req      in   valid / ready    in_item_t: command item
//  rsp      out  valid / ready    out_item_t: draw order item
//
// An item yields one draw order, or two (a draw followed by a scroll); while
// the second is pending the back part takes no new item. An accepted item passes
// through the queue and then the output register before its first result appears.
// The two-entry queue lets the front keep accepting while results stall.
// Reset clears the cursor, the queue and the output; config takes its defaults.
// Configuration writes are always accepted.
module text_console_cursor_engine (
	input  logic      clk,
	input  logic      arst_n,
	tcc_cfg_if.sink   cfg,
	tcc_in_if.sink    req,
	tcc_out_if.source rsp
);

	tcc_pkg::cfg_t      cfg_q;
	tcc_pkg::q_entry_t  wr_entry;
	tcc_pkg::q_entry_t  head;
	tcc_pkg::q_stat_t   q_stat;
	logic               push;
	logic               pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg_color       <= 24'hFFFFFF;
			cfg_q.backdrop_color <= 24'h000000;
			cfg_q.columns        <= 8'd128;
			cfg_q.rows           <= 8'd48;
		end else if (cfg.valid) begin
			case (cfg.index)
				tcc_pkg::REG_FG_COLOR:       cfg_q.fg_color       <= cfg.wdata;
				tcc_pkg::REG_BACKDROP_COLOR: cfg_q.backdrop_color <= cfg.wdata;
				tcc_pkg::REG_COLUMNS:        cfg_q.columns        <= cfg.wdata[7:0];
				tcc_pkg::REG_ROWS:           cfg_q.rows           <= cfg.wdata[7:0];
				default:                     cfg_q.rows           <= cfg_q.rows;
			endcase
		end
	end

	tcc_front u_front (
		.req   (req),
		.stat  (q_stat),
		.push  (push),
		.entry (wr_entry)
	);

	tcc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	tcc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.stat   (q_stat),
		.pop    (pop),
		.rsp    (rsp)
	);

	// The second result of an item follows straight after the first is taken.
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !rsp.data.last |=> rsp.valid)
		else $error("second result of an item did not follow");

	// Only a glyph, erase or block draw can be followed by a scroll.
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.last |->
			(rsp.data.op == tcc_pkg::OP_GLYPH || rsp.data.op == tcc_pkg::OP_ERASE ||
			 rsp.data.op == tcc_pkg::OP_RECT))
		else $error("unexpected order ahead of a second result");

	// A cursor-only result stands alone and carries no colour.
	a_cursor_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.op == tcc_pkg::OP_CURSOR |->
			rsp.data.last && rsp.data.color == 24'd0)
		else $error("malformed cursor-only result");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

endmodule
